FILE: hdl/rhcc_pkg.sv
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types and constants
// Transaction structs, fixed-point constants and the divider width of the
// RGB/HSV converter.
// ----------------------------------------------------------------------------
package rhcc_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [16:0] ONE_Q = 17'h10000;
	// Quotient bits produced by the restoring divider chain.
	localparam int QBITS = 17;
	// Divisor width (6*d fits in 11 bits).
	localparam int DBITS = 11;

	typedef enum logic {
		OP_RGB2HSV = 1'b0,
		OP_HSV2RGB = 1'b1
	} op_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [15:0] hue_in;
		logic [16:0] sat_in;
		logic [16:0] val_in;
	} in_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [15:0] hue_out;
		logic [16:0] sat_out;
		logic [16:0] val_out;
	} out_t;

	// Two divisions travel in lockstep down the chain: saturation and hue.
	typedef struct packed {
		logic [DBITS+QBITS-1:0] rem;  // partial remainder, left-aligned numerator
		logic [QBITS-1:0]       quo;
	} div_lane_t;

	typedef struct packed {
		logic        vld;
		logic        opcode;
		logic        hue_zero;
		logic [16:0] val;
		logic [7:0]  sat_den;
		logic [DBITS-1:0] hue_den;
		div_lane_t   sat_d;
		div_lane_t   hue_d;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} cell_t;

	function automatic logic [7:0] to_byte(input logic [16:0] x);
		logic [24:0] c;
		c = ({8'd0, x} << 8) - {8'd0, x};
		return (c[24:16] > 9'd255) ? 8'd255 : c[23:16];
	endfunction

endpackage

FILE: hdl/rhcc_div_cell.sv
// ----------------------------------------------------------------------------
// rhcc_div_cell: one restoring division step
// Retires one quotient bit of both the saturation and hue divisions and
// hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module rhcc_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  rhcc_pkg::cell_t d,
	output rhcc_pkg::cell_t q
);

	localparam int SH = rhcc_pkg::QBITS - 1;

	function automatic rhcc_pkg::div_lane_t step(input rhcc_pkg::div_lane_t l,
		input logic [rhcc_pkg::DBITS-1:0] den);
		rhcc_pkg::div_lane_t o;
		logic [rhcc_pkg::DBITS+1:0] top;
		logic [rhcc_pkg::DBITS+1:0] diff;
		top = {1'b0, l.rem[rhcc_pkg::DBITS+rhcc_pkg::QBITS-1:SH]};
		diff = top - {2'b00, den};
		o = l;
		if (!diff[rhcc_pkg::DBITS+1]) begin
			o.rem[rhcc_pkg::DBITS+rhcc_pkg::QBITS-1:SH] = diff[rhcc_pkg::DBITS:0];
			o.quo = {l.quo[rhcc_pkg::QBITS-2:0], 1'b1};
		end else begin
			o.quo = {l.quo[rhcc_pkg::QBITS-2:0], 1'b0};
		end
		o.rem = {o.rem[rhcc_pkg::DBITS+rhcc_pkg::QBITS-2:0], 1'b0};
		return o;
	endfunction

	rhcc_pkg::cell_t nxt;
	rhcc_pkg::cell_t dat_q;
	logic            vld_q;

	always_comb begin
		nxt = d;
		nxt.sat_d = step(d.sat_d, {3'd0, d.sat_den});
		nxt.hue_d = step(d.hue_d, d.hue_den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		dat_q <= nxt;
	end

	always_comb begin
		q     = dat_q;
		q.vld = vld_q;
	end

endmodule

FILE: hdl/rhcc_hsv2rgb.sv
// ----------------------------------------------------------------------------
// rhcc_hsv2rgb: HSV to RGB datapath
// Four registered stages: sector split, s*f products, v products, bytes.
// ----------------------------------------------------------------------------
module rhcc_hsv2rgb (
	input  logic        clk,
	input  logic [15:0] hue,
	input  logic [16:0] sat,
	input  logic [16:0] val,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic [16:0] s_c, v_c;
	logic [18:0] h6;

	logic [2:0]  sec_s1;
	logic [15:0] f_s1;
	logic [16:0] s_s1, v_s1;

	logic [2:0]  sec_s2;
	logic [16:0] v_s2, oms_s2, omsf_s2, omsnf_s2;
	logic [33:0] sf, snf;

	logic [2:0]  sec_s3;
	logic [16:0] v_s3, p_s3, q_s3, t_s3;
	logic [33:0] pp, qp, tp;

	logic [16:0] rr, gg, bb;

	assign s_c = (sat > rhcc_pkg::ONE_Q) ? rhcc_pkg::ONE_Q : sat;
	assign v_c = (val > rhcc_pkg::ONE_Q) ? rhcc_pkg::ONE_Q : val;
	assign h6  = ({3'd0, hue} << 2) + ({3'd0, hue} << 1);

	always_ff @(posedge clk) begin
		// zero saturation yields p=q=t=v, which gives gray through the same path
		sec_s1 <= h6[18:16];
		f_s1   <= h6[15:0];
		s_s1   <= s_c;
		v_s1   <= v_c;
	end

	assign sf  = s_s1 * {1'b0, f_s1};
	assign snf = s_s1 * (rhcc_pkg::ONE_Q - {1'b0, f_s1});

	always_ff @(posedge clk) begin
		sec_s2   <= sec_s1;
		v_s2     <= v_s1;
		oms_s2   <= rhcc_pkg::ONE_Q - s_s1;
		omsf_s2  <= rhcc_pkg::ONE_Q - sf[32:16];
		omsnf_s2 <= rhcc_pkg::ONE_Q - snf[32:16];
	end

	assign pp = v_s2 * oms_s2;
	assign qp = v_s2 * omsf_s2;
	assign tp = v_s2 * omsnf_s2;

	always_ff @(posedge clk) begin
		sec_s3 <= sec_s2;
		v_s3   <= v_s2;
		p_s3   <= pp[32:16];
		q_s3   <= qp[32:16];
		t_s3   <= tp[32:16];
	end

	always_comb begin
		unique case (sec_s3)
			3'd0:    begin rr = v_s3; gg = t_s3; bb = p_s3; end
			3'd1:    begin rr = q_s3; gg = v_s3; bb = p_s3; end
			3'd2:    begin rr = p_s3; gg = v_s3; bb = t_s3; end
			3'd3:    begin rr = p_s3; gg = q_s3; bb = v_s3; end
			3'd4:    begin rr = t_s3; gg = p_s3; bb = v_s3; end
			default: begin rr = v_s3; gg = p_s3; bb = q_s3; end
		endcase
	end

	always_ff @(posedge clk) begin
		red   <= rhcc_pkg::to_byte(rr);
		green <= rhcc_pkg::to_byte(gg);
		blue  <= rhcc_pkg::to_byte(bb);
	end

endmodule

FILE: hdl/rgb_hsv_color_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_unit: RGB <-> HSV converter
// Both opcodes pass through equally deep register paths from start to done.
// Throughput: one transaction per cycle; busy is tied low.
// The divider chain has 17 restoring cells (one quotient bit per cell).
// Reset: arst_n clears only the valid chain; no results after reset until
// a new start. The receiver cannot stall; done pulses for one cycle.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rhcc_pkg::in_t  cmd,
	output logic           done,
	output rhcc_pkg::out_t result
);

	localparam int N = rhcc_pkg::QBITS;

	rhcc_pkg::cell_t chain [0:N];
	rhcc_pkg::cell_t head_nxt;
	rhcc_pkg::cell_t head_dat_s1;
	logic head_vld_s1;
	rhcc_pkg::cell_t head_s1;
	logic [7:0] mx, mn, d;
	logic [10:0] d6, nn;
	logic [7:0] hr, hg, hb;
	logic [16:0] vq;
	logic [24:0] vprod;
	logic done_q;
	rhcc_pkg::out_t res_q;

	// The pipeline never blocks
	assign busy = 1'b0;

	// ---- setup stage: max/min, numerators and denominators -----------------
	always_comb begin
		mx = cmd.red_in;
		if (cmd.green_in > mx) mx = cmd.green_in;
		if (cmd.blue_in > mx)  mx = cmd.blue_in;
		mn = cmd.red_in;
		if (cmd.green_in < mn) mn = cmd.green_in;
		if (cmd.blue_in < mn)  mn = cmd.blue_in;
		d  = mx - mn;
		d6 = ({3'd0, d} << 2) + ({3'd0, d} << 1);
		// hue numerator n < 6d, so quotient n*2^16/(6d) < 2^16
		priority if (mx == cmd.red_in) begin
			nn = (cmd.green_in >= cmd.blue_in) ?
				{3'd0, cmd.green_in} - {3'd0, cmd.blue_in} :
				d6 - ({3'd0, cmd.blue_in} - {3'd0, cmd.green_in});
		end else if (mx == cmd.green_in) begin
			nn = {3'd0, cmd.blue_in} + ({3'd0, d} << 1) - {3'd0, cmd.red_in};
		end else begin
			nn = {3'd0, cmd.red_in} + ({3'd0, d} << 2) - {3'd0, cmd.green_in};
		end
		// val = floor(mx*65536/255) = floor((mx*65793 + 1)/256) for mx <= 255
		vprod = {9'd0, mx, 8'd0} + {17'd0, mx} + {1'b0, mx, 16'd0} + 25'd1;
		vq = vprod[24:8];
	end

	always_comb begin
		head_nxt.vld      = start & ~busy;
		head_nxt.opcode   = cmd.opcode;
		head_nxt.hue_zero = (d == 8'd0);
		head_nxt.val      = vq;
		head_nxt.sat_den  = mx;
		head_nxt.hue_den  = d6;
		// numerators start shifted so the cell's top window sees them bit by bit
		head_nxt.sat_d.rem = {{(rhcc_pkg::DBITS+N-8-1){1'b0}}, d, 1'b0} << 15;
		head_nxt.sat_d.quo = '0;
		head_nxt.hue_d.rem = {{(N-1){1'b0}}, nn, 1'b0} << 15;
		head_nxt.hue_d.quo = '0;
		head_nxt.red      = 8'd0;
		head_nxt.green    = 8'd0;
		head_nxt.blue     = 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_s1 <= 1'b0;
		end else begin
			head_vld_s1 <= head_nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		head_dat_s1 <= head_nxt;
	end

	always_comb begin
		head_s1     = head_dat_s1;
		head_s1.vld = head_vld_s1;
	end

	assign chain[0] = head_s1;

	// ---- division chain: one quotient bit per cell -------------------------
	for (genvar i = 0; i < N; i++) begin : g_cell
		rhcc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// ---- HSV to RGB path, delayed to line up with the chain ---------------
	rhcc_hsv2rgb u_h2r (
		.clk   (clk),
		.hue   (cmd.hue_in),
		.sat   (cmd.sat_in),
		.val   (cmd.val_in),
		.red   (hr),
		.green (hg),
		.blue  (hb)
	);

	localparam int DLY = N + 1 - 4;
	logic [23:0] rgb_q [0:DLY-1];

	always_ff @(posedge clk) begin
		rgb_q[0] <= {hr, hg, hb};
		for (int k = 1; k < DLY; k++) begin
			rgb_q[k] <= rgb_q[k-1];
		end
	end

	// ---- output register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[N].opcode == rhcc_pkg::OP_RGB2HSV) begin
			res_q.red_out   <= 8'd0;
			res_q.green_out <= 8'd0;
			res_q.blue_out  <= 8'd0;
			res_q.hue_out   <= chain[N].hue_zero ? 16'd0 : chain[N].hue_d.quo[15:0];
			res_q.sat_out   <= (chain[N].sat_den == 8'd0) ? 17'd0 : chain[N].sat_d.quo;
			res_q.val_out   <= chain[N].val;
		end else begin
			res_q.red_out   <= rgb_q[DLY-1][23:16];
			res_q.green_out <= rgb_q[DLY-1][15:8];
			res_q.blue_out  <= rgb_q[DLY-1][7:0];
			res_q.hue_out   <= 16'd0;
			res_q.sat_out   <= 17'd0;
			res_q.val_out   <= 17'd0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: test/rgb_hsv_color_converter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_unit_tb: self-checking bench for the color converter
// Drives directed and random RGB->HSV and HSV->RGB transactions, predicts each
// result with a bit-exact fixed-point model and compares it field by field.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_unit_tb;

	localparam int LATENCY   = 19;
	localparam int WDOG_MAX  = 2000;
	localparam int N_RANDOM  = 1800;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	rhcc_pkg::in_t   cmd = '0;
	logic            done;
	rhcc_pkg::out_t  result;

	rhcc_pkg::in_t   pending_q[$];     // transactions waiting to be driven
	rhcc_pkg::out_t  expected_q[$];    // predicted results, oldest first
	int     errors = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     n_hsv2rgb = 0;
	int     idle_pct = 0;     // sender idle chance in percent
	int     wdog = 0;
	bit     stim_done = 1'b0;

	rgb_hsv_color_converter_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	// Q16 product truncation helper for the HSV->RGB path
	function automatic logic [63:0] byte_of(input logic [63:0] x);
		logic [63:0] c;
		c = (x * 255) >> rhcc_pkg::FRAC_BITS;
		return (c > 255) ? 64'd255 : c;
	endfunction

	// Bit-exact color conversion predictor
	function automatic rhcc_pkg::out_t convert_color(input rhcc_pkg::in_t t);
		rhcc_pkg::out_t o;
		logic [63:0] r, g, b, mx, mn, d, n, one;
		logic [63:0] h, s, v, h6, f, p, q, tt, rr, gg, bb;
		int sector;
		one = 64'd1 << rhcc_pkg::FRAC_BITS;
		o = '0;
		if (rhcc_pkg::op_t'(t.opcode) == rhcc_pkg::OP_RGB2HSV) begin
			r = t.red_in; g = t.green_in; b = t.blue_in;
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			o.val_out = 17'((mx * one) / 255);
			o.sat_out = (mx == 0) ? 17'd0 : 17'((d * one) / mx);
			if (d != 0) begin
				// hue sector picked by the max channel, red wins ties
				if (mx == r)
					n = (g >= b) ? (g - b) : (6 * d - (b - g));
				else if (mx == g)
					n = b + 2 * d - r;
				else
					n = r + 4 * d - g;
				o.hue_out = 16'(((n * one) / (6 * d)) & (one - 1));
			end
		end else begin
			h = t.hue_in;
			s = (t.sat_in > one) ? one : t.sat_in;
			v = (t.val_in > one) ? one : t.val_in;
			if (s == 0) begin
				// gray
				o.red_out = 8'(byte_of(v));
				o.green_out = o.red_out;
				o.blue_out = o.red_out;
			end else begin
				h6 = (h & (one - 1)) * 6;
				sector = int'(h6 >> rhcc_pkg::FRAC_BITS);
				f = h6 & (one - 1);
				p = (v * (one - s)) >> rhcc_pkg::FRAC_BITS;
				q = (v * (one - ((s * f) >> rhcc_pkg::FRAC_BITS))) >> rhcc_pkg::FRAC_BITS;
				tt = (v * (one - ((s * (one - f)) >> rhcc_pkg::FRAC_BITS)))
					>> rhcc_pkg::FRAC_BITS;
				case (sector)
					0: begin rr = v;  gg = tt; bb = p;  end
					1: begin rr = q;  gg = v;  bb = p;  end
					2: begin rr = p;  gg = v;  bb = tt; end
					3: begin rr = p;  gg = q;  bb = v;  end
					4: begin rr = tt; gg = p;  bb = v;  end
					default: begin rr = v; gg = p; bb = q; end
				endcase
				o.red_out = 8'(byte_of(rr));
				o.green_out = 8'(byte_of(gg));
				o.blue_out = 8'(byte_of(bb));
			end
		end
		return o;
	endfunction

	function automatic rhcc_pkg::in_t rgb_txn(input int r, input int g, input int b);
		rhcc_pkg::in_t t;
		logic [95:0] junk;
		junk = {$urandom, $urandom, $urandom};   // junk in unused fields
		t = junk[$bits(rhcc_pkg::in_t)-1:0];
		t.opcode = rhcc_pkg::OP_RGB2HSV;
		t.red_in = 8'(r); t.green_in = 8'(g); t.blue_in = 8'(b);
		return t;
	endfunction

	function automatic rhcc_pkg::in_t hsv_txn(input int h, input int s, input int v);
		rhcc_pkg::in_t t;
		logic [95:0] junk;
		junk = {$urandom, $urandom, $urandom};
		t = junk[$bits(rhcc_pkg::in_t)-1:0];
		t.opcode = rhcc_pkg::OP_HSV2RGB;
		t.hue_in = 16'(h); t.sat_in = 17'(s); t.val_in = 17'(v);
		return t;
	endfunction

	// Random saturation/value: mostly in range, sometimes at or above one
	function automatic int rand_q16();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	// Driver: start stays high across back-to-back transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_q.push_back(convert_color(cmd));
				n_sent <= n_sent + 1;
				if (rhcc_pkg::op_t'(cmd.opcode) == rhcc_pkg::OP_HSV2RGB)
					n_hsv2rgb <= n_hsv2rgb + 1;
			end
			if (!(start && busy)) begin
				if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					start <= 1'b1;
					cmd <= pending_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: results can't be stalled, so check on every done
	always @(posedge clk) begin
		rhcc_pkg::out_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors <= errors + 1;
			end else begin
				exp_r = expected_q.pop_front();
				n_checked <= n_checked + 1;
				if (result.red_out !== exp_r.red_out || result.green_out !== exp_r.green_out ||
				    result.blue_out !== exp_r.blue_out || result.hue_out !== exp_r.hue_out ||
				    result.sat_out !== exp_r.sat_out || result.val_out !== exp_r.val_out) begin
					$display("%0t: mismatch expected rgb=%0d/%0d/%0d hsv=%0d/%0d/%0d",
						$time, exp_r.red_out, exp_r.green_out, exp_r.blue_out,
						exp_r.hue_out, exp_r.sat_out, exp_r.val_out);
					$display("%0t:          actual rgb=%0d/%0d/%0d hsv=%0d/%0d/%0d",
						$time, result.red_out, result.green_out, result.blue_out,
						result.hue_out, result.sat_out, result.val_out);
					errors <= errors + 1;
				end
			end
		end
	end

	// Watchdog: counts cycles with no accepted transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || stim_done)
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("%0t: watchdog timeout, %0d results outstanding",
					$time, expected_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int k;
		int tail;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, grays, each max channel, ties, sectors
		pending_q.push_back(rgb_txn(0, 0, 0));
		pending_q.push_back(rgb_txn(255, 255, 255));
		pending_q.push_back(rgb_txn(128, 128, 128));
		pending_q.push_back(rgb_txn(255, 0, 0));
		pending_q.push_back(rgb_txn(0, 255, 0));
		pending_q.push_back(rgb_txn(0, 0, 255));
		pending_q.push_back(rgb_txn(255, 0, 1));   // red max, negative wrap
		pending_q.push_back(rgb_txn(255, 255, 0)); // red/green tie
		pending_q.push_back(rgb_txn(0, 255, 255)); // green/blue tie
		pending_q.push_back(rgb_txn(1, 0, 0));
		pending_q.push_back(hsv_txn(0, 0, 0));
		pending_q.push_back(hsv_txn(12345, 0, 40000));        // gray
		pending_q.push_back(hsv_txn(0, 65536, 65536));
		pending_q.push_back(hsv_txn(65535, 65536, 65536));
		pending_q.push_back(hsv_txn(65535, 131071, 131071)); // clamp above one
		for (k = 0; k < 6; k++)
			pending_q.push_back(hsv_txn(k * 10923 + 100, 50000, 60000));
		pending_q.push_back(hsv_txn(21845, 65537, 70000));
		pending_q.push_back(hsv_txn(43690, 1, 65536));

		// Random in three idling phases
		for (k = 0; k < N_RANDOM; k++) begin
			if (k % 2 == 0)
				pending_q.push_back(rgb_txn($urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255)));
			else
				pending_q.push_back(hsv_txn($urandom_range(0, 65535),
					rand_q16(), rand_q16()));
			if (k == N_RANDOM / 3) begin
				idle_pct = 25;
				while (pending_q.size() != 0) @(posedge clk);
				idle_pct = 76;
			end else if (k == 2 * N_RANDOM / 3) begin
				while (pending_q.size() != 0) @(posedge clk);
				idle_pct = 0;
			end
		end

		while (pending_q.size() != 0 || start) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		stim_done = 1'b1;
		tail = 0;
		while (tail < LATENCY + 10) begin
			@(posedge clk);
			tail++;
		end

		$display("Covered %0d transactions (%0d HSV->RGB), %0d results checked.",
			n_sent, n_hsv2rgb, n_checked);
		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
